>>> sv/sss_pkg.sv
`timescale 1ns / 1ps

package sss_pkg;

   localparam int MUL_W      = 32;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int COS_W      = 15;

   // Full-scale cosine and the rounding offset for the divide by full scale
   localparam logic [15:0] COS_FULL   = 16'd32767;
   localparam logic [29:0] ROUND_HALF = 30'd16383;

   // Quarter turn in Q30 radians
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_START_TIME  = 3'd0,
      CSR_MIN_FREQ    = 3'd1,
      CSR_MAX_FREQ    = 3'd2,
      CSR_FREQ_STEP   = 3'd3,
      CSR_NUM_PERIODS = 3'd4,
      CSR_AMPLITUDE   = 3'd5,
      CSR_BIAS        = 3'd6,
      CSR_FRICTION    = 3'd7
   } csr_index_type;

   // Quarter-wave cosine entry, evaluated at elaboration only
   function automatic logic [COS_W-1:0] cos_entry(input int unsigned idx,
                                                  input int unsigned bits);
      logic [63:0]        th;
      logic [63:0]        th2;
      logic [63:0]        term;
      logic signed [63:0] sum;
      logic signed [63:0] e;
      th   = (64'(idx) * HALF_PI_Q30) >> bits;
      th2  = (th * th) >> 30;
      term = 64'd1 << 30;
      sum  = signed'(term);
      // Taylor series divisors are (2k-1)(2k)
      for (int k = 1; k <= 12; k++) begin
         term = ((term * th2) >> 30) / 64'((2 * k - 1) * (2 * k));
         if ((k % 2) == 1) begin
            sum = sum - signed'(term);
         end else begin
            sum = sum + signed'(term);
         end
      end
      if (sum < 0) begin
         sum = 64'sd0;
      end
      e = (sum * 64'sd32767 + (64'sd1 <<< 29)) >>> 30;
      if (e > 64'sd32767) begin
         e = 64'sd32767;
      end
      return e[COS_W-1:0];
   endfunction

endpackage

>>> sv/sss_mul.sv
`timescale 1ns / 1ps

module sss_mul (
   input  logic                           clock,
   input  logic [sss_pkg::MUL_W-1:0]      op_a,
   input  logic [sss_pkg::MUL_W-1:0]      op_b,
   output logic [2*sss_pkg::MUL_W-1:0]    product
);
   import sss_pkg::*;

   logic [2*MUL_W-1:0] product_ff;

   always_ff @(posedge clock) begin
      product_ff <= op_a * op_b;
   end

   assign product = product_ff;

endmodule

>>> sv/sss_cos_rom.sv
`timescale 1ns / 1ps

module sss_cos_rom #(
   parameter int COS_TABLE_BITS = 10
) (
   input  logic                       clock,
   input  logic [COS_TABLE_BITS-1:0]  rd_addr,
   output logic [sss_pkg::COS_W-1:0]  rd_data
);
   import sss_pkg::*;

   localparam int TableSize = 1 << COS_TABLE_BITS;

   logic [COS_W-1:0] cos_rom [TableSize];

   // Quarter-wave cosine entries, fixed at elaboration
   for (genvar gi = 0; gi < TableSize; gi++) begin : g_entry
      localparam logic [COS_W-1:0] Entry = cos_entry(gi, COS_TABLE_BITS);
      assign cos_rom[gi] = Entry;
   end

   logic [COS_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      rd_data_ff <= cos_rom[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/stepped_sine_sweep_generator.sv
// Stepped sine sweep generator. Each req item is one sample tick carrying the
// tick number and the motor velocity; each yields exactly one rsp item with
// the current frequency increment, the sweep signal (amplitude * cosine of the
// accumulated phase, plus bias) before and after friction compensation, and a
// sweep-done flag. Before start_time, or once the sweep has ended, the signal
// is the bias alone. When the whole turns in the current segment reach
// num_periods the frequency steps by freq_step (saturating), or the sweep ends
// if the frequency already exceeds max_freq. Writing min_freq restarts the
// sweep. An item passes through FREQ_MUL, PHASE, AMP_MUL, SCALE and HOLD,
// where HOLD waits out any output stall: one 32x32 multiplier is shared by
// the phase product and the amplitude scaling, and the cosine ROM adds one
// registered read. A new item is taken only after the previous result has
// been loaded into the output register.
`timescale 1ns / 1ps

module stepped_sine_sweep_generator #(
   parameter int COS_TABLE_BITS = 10,
   parameter int OUT_WIDTH      = 16,
   localparam int RspBits = ((2 * OUT_WIDTH + 33 + 7) / 8) * 8
) (
   input  logic                              clock,
   input  logic                              reset,
   // req item
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [63:0]                       req_tdata,  // time_now, velocity
   // rsp item
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // freq_out, observe_out, drive_out, sweep_done, zero fill
   output logic [RspBits-1:0]                rsp_tdata,
   // configuration writes
   input  logic                              csr_we,
   input  logic [sss_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [sss_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import sss_pkg::*;

   localparam int WideW = (OUT_WIDTH > 19) ? OUT_WIDTH + 1 : 20;
   localparam logic signed [WideW-1:0] OutMax =
      WideW'((64'sd1 <<< (OUT_WIDTH - 1)) - 64'sd1);
   localparam logic signed [WideW-1:0] OutMin = -OutMax - WideW'(1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FREQ_MUL,
      ST_PHASE,
      ST_AMP_MUL,
      ST_SCALE,
      ST_HOLD
   } state_type;

   function automatic logic signed [OUT_WIDTH-1:0] sat_out(
      input logic signed [WideW-1:0] v);
      logic signed [WideW-1:0] r;
      r = v;
      if (v > OutMax) begin
         r = OutMax;
      end else if (v < OutMin) begin
         r = OutMin;
      end
      return r[OUT_WIDTH-1:0];
   endfunction

   // Configuration registers
   logic [31:0]        start_time_ff;
   logic [31:0]        max_freq_ff;
   logic [31:0]        freq_step_ff;
   logic [15:0]        num_periods_ff;
   logic [14:0]        amplitude_ff;
   logic signed [15:0] bias_ff;
   logic signed [15:0] friction_ff;

   // Sweep state
   logic [31:0]        freq_ff;
   logic [31:0]        seg_start_ff;
   logic               ended_ff;

   // Per-item working registers
   state_type          state_ff;
   logic [31:0]        t_ff;
   logic [31:0]        dt_ff;
   logic               active_ff;
   logic               neg_vel_ff;
   logic               seg_end_ff;
   logic               cos_neg_ff;
   logic               cos_zero_ff;
   logic signed [OUT_WIDTH-1:0] observe_ff;
   logic signed [OUT_WIDTH-1:0] drive_ff;

   // Output register
   logic               rsp_tvalid_ff;
   logic [RspBits-1:0] rsp_tdata_ff;

   // Shared multiplier and cosine ROM
   logic [MUL_W-1:0]           mul_a;
   logic [MUL_W-1:0]           mul_b;
   logic [2*MUL_W-1:0]         mul_product;
   logic [COS_TABLE_BITS-1:0]  rom_addr;
   logic [COS_W-1:0]           rom_data;

   sss_mul u_mul (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .product (mul_product)
   );

   sss_cos_rom #(
      .COS_TABLE_BITS (COS_TABLE_BITS)
   ) u_rom (
      .clock   (clock),
      .rd_addr (rom_addr),
      .rd_data (rom_data)
   );

   // Input decode
   logic [31:0] req_time;
   logic        req_neg_vel;
   logic        req_accept;
   logic [31:0] t_in;

   assign req_time    = req_tdata[31:0];
   assign req_neg_vel = req_tdata[63];
   assign req_tready  = (state_ff == ST_IDLE);
   assign req_accept  = req_tvalid && req_tready;
   assign t_in        = req_time - start_time_ff;

   // Multiplier operands: phase product first, then amplitude scaling
   always_comb begin
      if (state_ff == ST_FREQ_MUL) begin
         mul_a = freq_ff;
         mul_b = dt_ff;
      end else begin
         mul_a = MUL_W'(amplitude_ff);
         mul_b = cos_zero_ff ? '0 : MUL_W'(rom_data);
      end
   end

   // Phase decode: quadrant picks forward or mirrored table entry and sign
   logic [1:0]                quad;
   logic [COS_TABLE_BITS-1:0] idx;
   logic                      seg_end_in;
   logic                      cos_neg_in;
   logic                      cos_zero_in;

   assign quad        = mul_product[31:30];
   assign idx         = mul_product[29 -: COS_TABLE_BITS];
   assign rom_addr    = quad[0] ? (COS_TABLE_BITS'(0) - idx) : idx;
   assign cos_zero_in = quad[0] && (idx == '0);
   assign cos_neg_in  = quad[1] ^ quad[0];
   // Whole turns reached: product >= num_periods * 2^32
   assign seg_end_in  = (mul_product[63:32] >= {16'd0, num_periods_ff});

   // Scale by amplitude / 32767, rounded half away from zero:
   // quotient is x>>15 or one more, settled by one compare
   logic [29:0]        scaled_x;
   logic [14:0]        quot_lo;
   logic [15:0]        rem;
   logic [15:0]        mag;
   logic signed [17:0] signal;
   logic signed [18:0] drive;
   logic [32:0]        freq_sum;
   logic [31:0]        freq_next;

   assign scaled_x = mul_product[29:0] + ROUND_HALF;
   assign quot_lo  = scaled_x[29:15];
   assign rem      = {1'b0, scaled_x[14:0]} + {1'b0, quot_lo};
   assign mag      = (rem >= COS_FULL) ? ({1'b0, quot_lo} + 16'd1) : {1'b0, quot_lo};

   always_comb begin
      signal = 18'(bias_ff);
      if (active_ff) begin
         if (cos_neg_ff) begin
            signal = signal - signed'({2'b00, mag});
         end else begin
            signal = signal + signed'({2'b00, mag});
         end
      end
      if (neg_vel_ff) begin
         drive = 19'(signal) - 19'(friction_ff);
      end else begin
         drive = 19'(signal) + 19'(friction_ff);
      end
   end

   // Frequency step saturates at all ones
   assign freq_sum  = {1'b0, freq_ff} + {1'b0, freq_step_ff};
   assign freq_next = freq_sum[32] ? '1 : freq_sum[31:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rsp_tvalid_ff  <= 1'b0;
         start_time_ff  <= '0;
         max_freq_ff    <= '0;
         freq_step_ff   <= '0;
         num_periods_ff <= 16'd1;
         amplitude_ff   <= '0;
         bias_ff        <= '0;
         friction_ff    <= '0;
         freq_ff        <= '0;
         seg_start_ff   <= '0;
         ended_ff       <= 1'b0;
      end else begin
         // Drop the result once the consumer takes it, unless the next loads now
         if (rsp_tvalid_ff && rsp_tready && (state_ff != ST_HOLD)) begin
            rsp_tvalid_ff <= 1'b0;
         end

         // Configuration writes are to arrive only while idle; the block does not enforce this
         if (csr_we) begin
            case (csr_index_type'(csr_addr))
               CSR_START_TIME:  start_time_ff <= csr_wdata;
               CSR_MIN_FREQ: begin
                  // Restart the sweep from the new first frequency
                  freq_ff      <= csr_wdata;
                  seg_start_ff <= '0;
                  ended_ff     <= 1'b0;
               end
               CSR_MAX_FREQ:    max_freq_ff    <= csr_wdata;
               CSR_FREQ_STEP:   freq_step_ff   <= csr_wdata;
               CSR_NUM_PERIODS: num_periods_ff <= csr_wdata[15:0];
               CSR_AMPLITUDE:   amplitude_ff   <= csr_wdata[14:0];
               CSR_BIAS:        bias_ff        <= signed'(csr_wdata[15:0]);
               CSR_FRICTION:    friction_ff    <= signed'(csr_wdata[15:0]);
               default: ;
            endcase
         end

         case (state_ff)
            ST_IDLE: begin
               // Capture the tick and elapsed count in the segment
               if (req_accept) begin
                  t_ff       <= t_in;
                  dt_ff      <= t_in - seg_start_ff;
                  active_ff  <= (req_time >= start_time_ff) && !ended_ff;
                  neg_vel_ff <= req_neg_vel;
                  state_ff   <= ST_FREQ_MUL;
               end
            end
            ST_FREQ_MUL: begin
               // Multiplier forms freq * dt this cycle
               state_ff <= ST_PHASE;
            end
            ST_PHASE: begin
               // ROM read issued from the phase; hold quadrant info
               seg_end_ff  <= seg_end_in;
               cos_neg_ff  <= cos_neg_in;
               cos_zero_ff <= cos_zero_in;
               state_ff    <= ST_AMP_MUL;
            end
            ST_AMP_MUL: begin
               // Multiplier forms amplitude * |cos| this cycle
               state_ff <= ST_SCALE;
            end
            ST_SCALE: begin
               observe_ff <= sat_out(WideW'(signal));
               drive_ff   <= sat_out(WideW'(drive));
               // Segment change or end of sweep
               if (active_ff && seg_end_ff) begin
                  if (freq_ff <= max_freq_ff) begin
                     seg_start_ff <= t_ff;
                     freq_ff      <= freq_next;
                  end else begin
                     ended_ff <= 1'b1;
                  end
               end
               state_ff <= ST_HOLD;
            end
            ST_HOLD: begin
               // Load the output register as soon as it is free
               if (!rsp_tvalid_ff || rsp_tready) begin
                  rsp_tvalid_ff <= 1'b1;
                  rsp_tdata_ff  <= RspBits'({ended_ff, drive_ff, observe_ff, freq_ff});
                  state_ff      <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

endmodule
